// ===== sv/lmbps_pkg.sv =====
// Shared types and constants for the LED matrix bit-plane scanner.
// No dependencies; used by every module of the block.
package lmbps_pkg;

  localparam int NUM_ROWS   = 16;
  localparam int NUM_COLS   = 4;
  localparam int ROW_W      = 4;
  localparam int COL_W      = 2;
  localparam int LEVEL_W    = 8;
  localparam int PLANE_W    = 3;
  localparam int DEPTH_DEF  = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    FUNC_PIXEL = 2'd0,
    FUNC_ALL   = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  // Store update request from the work stage
  typedef struct packed {
    logic               wr_pix;
    logic               wr_all;
    logic [2:0]         x;
    logic [2:0]         y;
    logic [LEVEL_W-1:0] level;
  } pix_cmd_t;

  // Row and plane that the current tick will drive
  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [PLANE_W-1:0] plane;
  } scan_pos_t;

endpackage

// ===== sv/lmbps_store.sv =====
// Pixel store: one DEPTH-bit level per pixel, kept per column, plus a fill level
// and per-pixel valid bits so a set-all needs no write to the levels. Depends on lmbps_pkg.
module lmbps_store #(
  parameter int DEPTH = lmbps_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lmbps_pkg::pix_cmd_t           cmd,
  input  lmbps_pkg::scan_pos_t          rd_pos,
  output logic [lmbps_pkg::NUM_COLS-1:0] rd_cols
);
  import lmbps_pkg::*;

  logic [DEPTH-1:0]    kept;
  logic [ROW_W-1:0]    wr_row;
  logic [COL_W-1:0]    wr_col;
  logic [DEPTH-1:0]    fill_r;
  logic [NUM_COLS-1:0] vld_r [NUM_ROWS];

  assign kept   = cmd.level[LEVEL_W-1 -: DEPTH];
  assign wr_row = {cmd.x[2], cmd.y};
  assign wr_col = cmd.x[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      for (int r = 0; r < NUM_ROWS; r++) vld_r[r] <= '0;
    end else if (cmd.wr_all) begin
      fill_r <= kept;
      for (int r = 0; r < NUM_ROWS; r++) vld_r[r] <= '0;
    end else if (cmd.wr_pix) begin
      vld_r[wr_row][wr_col] <= 1'b1;
    end
  end

  for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
    logic [DEPTH-1:0] lvl_r [NUM_ROWS];
    logic [DEPTH-1:0] lvl_rd;
    logic [DEPTH-1:0] lvl_sh;

    always_ff @(posedge clk) begin
      if (cmd.wr_pix && !cmd.wr_all && wr_col == COL_W'(c)) begin
        lvl_r[wr_row] <= kept;
      end
    end

    // an entry not written since the last set-all reads as the fill level
    assign lvl_rd     = vld_r[rd_pos.row][c] ? lvl_r[rd_pos.row] : fill_r;
    assign lvl_sh     = lvl_rd >> rd_pos.plane;
    assign rd_cols[c] = lvl_sh[0];
  end

endmodule

// ===== sv/lmbps_seq.sv =====
// Scan sequencer: row counter, sequence position and the plane for each tick.
// Depends on lmbps_pkg.
module lmbps_seq #(
  parameter int DEPTH = lmbps_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  output lmbps_pkg::scan_pos_t pos
);
  import lmbps_pkg::*;

  localparam logic [DEPTH-1:0] SEQ_LEN = {DEPTH{1'b1}};

  logic [ROW_W-1:0] row_r, row_nxt;
  logic [DEPTH-1:0] seq_r, seq_nxt;
  logic [DEPTH-1:0] seq_inc;
  logic [DEPTH-1:0] seq_p1;
  int               tz;

  assign row_nxt = row_r + 1'b1;
  assign seq_inc = seq_r + 1'b1;

  always_comb begin
    seq_nxt = seq_r;
    if (row_nxt == '0) begin
      seq_nxt = (seq_inc >= SEQ_LEN) ? '0 : seq_inc;
    end
  end

  // trailing zeros of position+1, capped at DEPTH-1
  assign seq_p1 = seq_nxt + 1'b1;
  always_comb begin
    tz = DEPTH - 1;
    for (int i = DEPTH - 2; i >= 0; i--) begin
      if (seq_p1[i]) tz = i;
    end
  end

  assign pos.row   = row_nxt;
  assign pos.plane = PLANE_W'(DEPTH - 1 - tz);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      seq_r <= '0;
    end else if (step) begin
      row_r <= row_nxt;
      seq_r <= seq_nxt;
    end
  end

endmodule

// ===== sv/led_matrix_bit_plane_scanner_unit.sv =====
// LED matrix bit-plane scanner, top level.
// Input stream: in_tuser carries the function (set pixel, set all, scan tick),
// in_tdata the pixel position and level. Pixel writes and set-all words give no
// output word; every scan tick gives one output word with the port value
// (row in the upper nibble, column bits of the shown plane in the lower), the
// plane and the row, and in out_tuser the demux-off flag.
// cfg_wr_en/cfg_wr_data set scan_enable; with it low a tick gives an all-zero
// word with demux_off set and the scan counters hold.
// A tick sits in the input register and is then written to the output register,
// which drives out_tvalid; an output register that is full and not taken holds it.
// Throughput: one word per cycle; every item is a single pass through the work stage.
// The input register keeps taking words while an output word waits: only a
// tick that finds the output register full and not taken holds the work stage.
// Reset (synchronous, rst_n low) clears the pixel store to level zero, the row
// and sequence counters and scan_enable, and empties both registers.
// Depends on lmbps_pkg, lmbps_store, lmbps_seq.
module led_matrix_bit_plane_scanner_unit #(
  parameter int DEPTH = lmbps_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [2:0] pixel_x, [5:3] pixel_y, [13:6] level, [15:14] zero
  input  logic [lmbps_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] func
  input  logic [1:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] port_value, [10:8] plane_shown, [14:11] row_shown, [15] zero
  output logic [lmbps_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [0] demux_off
  output logic                              out_tuser,
  input  logic                              cfg_wr_en,
  input  logic                              cfg_wr_data
);
  import lmbps_pkg::*;

  logic               in_vld_r;
  func_t              in_func_r;
  logic [2:0]         in_x_r;
  logic [2:0]         in_y_r;
  logic [LEVEL_W-1:0] in_lvl_r;

  logic               scan_en_r;
  logic               out_vld_r;
  logic [7:0]         out_port_r;
  logic [PLANE_W-1:0] out_plane_r;
  logic [ROW_W-1:0]   out_row_r;
  logic               out_demux_r;

  logic                is_tick;
  logic                out_free;
  logic                proc;
  logic                step;
  pix_cmd_t            cmd;
  scan_pos_t           pos;
  logic [NUM_COLS-1:0] cols;

  assign is_tick   = (in_func_r == FUNC_TICK);
  assign out_free  = !out_vld_r || out_tready;
  assign proc      = in_vld_r && (!is_tick || out_free);
  assign in_tready = !in_vld_r || proc;
  assign step      = proc && is_tick && scan_en_r;

  always_comb begin
    cmd        = '0;
    cmd.x      = in_x_r;
    cmd.y      = in_y_r;
    cmd.level  = in_lvl_r;
    if (proc) begin
      case (in_func_r)
        FUNC_PIXEL: cmd.wr_pix = 1'b1;
        FUNC_ALL:   cmd.wr_all = 1'b1;
        default:    ;
      endcase
    end
  end

  lmbps_store #(.DEPTH(DEPTH)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd_pos  (pos),
    .rd_cols (cols)
  );

  lmbps_seq #(.DEPTH(DEPTH)) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .pos   (pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      scan_en_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_func_r <= func_t'(in_tuser);
      in_x_r    <= in_tdata[2:0];
      in_y_r    <= in_tdata[5:3];
      in_lvl_r  <= in_tdata[13:6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc && is_tick) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && is_tick) begin
      if (scan_en_r) begin
        out_port_r  <= {pos.row, cols};
        out_plane_r <= pos.plane;
        out_row_r   <= pos.row;
        out_demux_r <= 1'b0;
      end else begin
        // blank the port, hold the scan
        out_port_r  <= '0;
        out_plane_r <= '0;
        out_row_r   <= '0;
        out_demux_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_row_r, out_plane_r, out_port_r};
  assign out_tuser  = out_demux_r;

`ifndef NO_ASSERTIONS
  a_blank_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_demux_r |-> out_port_r == '0 && out_row_r == '0 && out_plane_r == '0)
    else $error("blanked word carries nonzero fields");

  a_row_nibble: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_demux_r |-> out_port_r[7:4] == out_row_r)
    else $error("port row nibble differs from row_shown");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !proc |-> is_tick && out_vld_r && !out_tready)
    else $error("work stage held without a blocked tick");

  a_tick_word: assert property (@(posedge clk) disable iff (!rst_n)
    proc && is_tick |=> out_vld_r)
    else $error("tick gave no output word");
`endif

endmodule
